FILE: src/fh64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fh64_pkg
// Shared constants, types and helper functions of the four-seed fasthash64.
// ----------------------------------------------------------------------------
package fh64_pkg;

  localparam int unsigned NUM_OUT         = 4;
  localparam int unsigned LANES_DEF       = 4;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned SEED_IDX_W      = $clog2(NUM_OUT);

  localparam logic [63:0] MULT_M = 64'h8803_55f2_1e6d_1965;
  localparam logic [63:0] MIX_C  = 64'h2127_599b_f432_5c37;

  localparam logic [CFG_IDX_W-1:0] CFG_FOLD = CFG_IDX_W'(NUM_OUT);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LEN,
    OP_SEED,
    OP_MUL_MIX,
    OP_MIX_POST,
    OP_MUL_LANE,
    OP_LANE_WB,
    OP_MUL_FIN,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic first;
    logic last;
    logic cnt_nz;
    logic open;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [63:0] mix_pre(input logic [63:0] v);
    return v ^ (v >> 23);
  endfunction

  function automatic logic [63:0] mix_post(input logic [63:0] v);
    return v ^ (v >> 47);
  endfunction

  function automatic logic [63:0] fold32(input logic [63:0] h);
    logic [31:0] f;
    f = h[31:0] - h[63:32];
    return {32'h0, f};
  endfunction

  // counts of eight or more keep all bytes
  function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (cnt > 4'(b)) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: src/fh64_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fh64_mul
// 64x64 multiply modulo 2^64 from three 32x32 partial products, one a cycle.
// ----------------------------------------------------------------------------
module fh64_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] prod_o,
  output logic             done_o
);

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic [63:0] a_q, b_q, acc_q;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] pp, term;

  always_comb begin
    case (step_q)
      STEP_LL: begin
        mul_a = a_q[31:0];
        mul_b = b_q[31:0];
      end
      STEP_LH: begin
        mul_a = a_q[31:0];
        mul_b = b_q[63:32];
      end
      default: begin
        mul_a = a_q[63:32];
        mul_b = b_q[31:0];
      end
    endcase
    pp   = 64'(mul_a) * 64'(mul_b);
    term = (step_q == STEP_LL) ? pp : {pp[31:0], 32'h0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_LL;
    end else begin
      done_q <= busy_q && (step_q == STEP_HL) && !start_i;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_LL;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == STEP_HL) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + term;
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: src/fh64_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fh64_datapath
// Word latch, lane hash registers, per-lane multipliers and result register.
// ----------------------------------------------------------------------------
module fh64_datapath #(
  parameter int unsigned LANES       = fh64_pkg::LANES_DEF,
  parameter int unsigned LENGTH_BITS = fh64_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire fh64_pkg::dp_cmd_t                     cmd_i,
  output fh64_pkg::dp_stat_t                         stat_o,
  input  wire logic [63:0]                           data_word_i,
  input  wire logic [3:0]                            byte_count_i,
  input  wire logic [LENGTH_BITS-1:0]                total_length_i,
  input  wire logic                                  first_word_i,
  input  wire logic                                  last_word_i,
  input  wire logic [fh64_pkg::NUM_OUT-1:0][63:0]    seed_i,
  input  wire logic                                  fold_i,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic      [fh64_pkg::NUM_OUT-1:0][63:0]    hash_o
);

  import fh64_pkg::*;

  logic [63:0] word_q, len_q, v_q;
  logic [3:0]  cnt_q;
  logic        first_q, last_q, open_q, out_valid_q;
  logic [LANES-1:0][63:0]   lane_q;
  logic [NUM_OUT-1:0][63:0] out_q;
  logic [LANES-1:0][63:0]   mul_a, mul_b, prod;
  logic [LANES-1:0]         done;
  logic        mul_start;
  logic [63:0] mix_in;

  assign mix_in    = mix_pre(word_q & byte_mask(cnt_q));
  assign mul_start = (cmd_i.op == OP_MUL_LEN) || (cmd_i.op == OP_MUL_MIX) ||
                     (cmd_i.op == OP_MUL_LANE) || (cmd_i.op == OP_MUL_FIN);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    always_comb begin
      mul_a[i] = lane_q[i] ^ v_q;
      mul_b[i] = MULT_M;
      unique case (cmd_i.op)
        OP_MUL_FIN: begin
          mul_a[i] = mix_pre(lane_q[i]);
          mul_b[i] = MIX_C;
        end
        OP_MUL_LEN: begin
          mul_a[i] = len_q;
        end
        OP_MUL_MIX: begin
          mul_a[i] = mix_in;
          mul_b[i] = MIX_C;
        end
        default: begin
        end
      endcase
    end

    fh64_mul u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (mul_start),
      .a_i     (mul_a[i]),
      .b_i     (mul_b[i]),
      .prod_o  (prod[i]),
      .done_o  (done[i])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lane_q[i] <= '0;
      end else if (cmd_i.op == OP_SEED) begin
        lane_q[i] <= ((i < NUM_OUT) ? seed_i[i % NUM_OUT] : 64'h0) ^ prod[0];
      end else if (cmd_i.op == OP_LANE_WB) begin
        lane_q[i] <= prod[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_SEED) begin
        open_q <= 1'b1;
      end else if (cmd_i.op == OP_EMIT) begin
        open_q <= 1'b0;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      word_q  <= data_word_i;
      cnt_q   <= byte_count_i;
      len_q   <= 64'(total_length_i);
      first_q <= first_word_i;
      last_q  <= last_word_i;
    end
    if (cmd_i.op == OP_MIX_POST) begin
      v_q <= mix_post(prod[0]);
    end
  end

  for (genvar j = 0; j < NUM_OUT; j++) begin : g_out
    if (j < LANES) begin : g_used
      always_ff @(posedge clk_i) begin
        if (cmd_i.op == OP_EMIT) begin
          out_q[j] <= fold_i ? fold32(mix_post(lane_q[j % LANES]))
                             : mix_post(lane_q[j % LANES]);
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk_i) begin
        if (cmd_i.op == OP_EMIT) begin
          out_q[j] <= '0;
        end
      end
    end
  end

  assign stat_o.mul_done = done[0];
  assign stat_o.first    = first_q;
  assign stat_o.last     = last_q;
  assign stat_o.cnt_nz   = (cnt_q != 4'd0);
  assign stat_o.open     = open_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign hash_o          = out_q;

endmodule
`default_nettype wire

FILE: src/fh64_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fh64_ctrl
// Sequencer: steps one word through seeding, mixing, lane update and finish.
// ----------------------------------------------------------------------------
module fh64_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire fh64_pkg::dp_stat_t stat_i,
  output fh64_pkg::dp_cmd_t       cmd_o
);

  import fh64_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_CHECK     = 11'b000_0000_0010,
    S_LEN_GO    = 11'b000_0000_0100,
    S_LEN_WAIT  = 11'b000_0000_1000,
    S_MIX_GO    = 11'b000_0001_0000,
    S_MIX_WAIT  = 11'b000_0010_0000,
    S_LANE_GO   = 11'b000_0100_0000,
    S_LANE_WAIT = 11'b000_1000_0000,
    S_FIN_GO    = 11'b001_0000_0000,
    S_FIN_WAIT  = 11'b010_0000_0000,
    S_EMIT      = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.first) begin
          state_d = S_LEN_GO;
        end else if (!stat_i.open) begin
          state_d = S_IDLE;
        end else if (stat_i.cnt_nz) begin
          state_d = S_MIX_GO;
        end else if (stat_i.last) begin
          state_d = S_FIN_GO;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LEN_GO: begin
        cmd_o.op = OP_MUL_LEN;
        state_d  = S_LEN_WAIT;
      end
      S_LEN_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_SEED;
          if (stat_i.cnt_nz) begin
            state_d = S_MIX_GO;
          end else if (stat_i.last) begin
            state_d = S_FIN_GO;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_MIX_GO: begin
        cmd_o.op = OP_MUL_MIX;
        state_d  = S_MIX_WAIT;
      end
      S_MIX_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_MIX_POST;
          state_d  = S_LANE_GO;
        end
      end
      S_LANE_GO: begin
        cmd_o.op = OP_MUL_LANE;
        state_d  = S_LANE_WAIT;
      end
      S_LANE_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_LANE_WB;
          state_d  = stat_i.last ? S_FIN_GO : S_IDLE;
        end
      end
      S_FIN_GO: begin
        cmd_o.op = OP_MUL_FIN;
        state_d  = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_LANE_WB;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

FILE: src/fasthash64_four_seed_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fasthash64_four_seed_top
// fasthash64 of a byte message under four seeds, one 64-bit word per item.
// ----------------------------------------------------------------------------
// A message is sent as little-endian 64-bit words; the first word carries the
// total length and the last word releases one result word holding all lane
// hashes. Each 64x64 product is built from three 32x32 partial products, one
// multiplier per lane, so cost is set by the chain of dependent multiplies: a
// middle word with bytes runs the mix multiply, then the lane multiply, before
// ready; a first word adds the length multiply, a last word adds the final mix
// multiply and then loads the result, and a word that is dropped, or a middle
// word with no bytes, returns to ready straight after its check. A new word is
// accepted while a result still waits at the output. Seeds and the fold bit
// must be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module fasthash64_four_seed_top #(
  parameter int unsigned LANES       = fh64_pkg::LANES_DEF,
  parameter int unsigned LENGTH_BITS = fh64_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fh64_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]                    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [63:0]                    data_word_i,
  input  wire logic [3:0]                     byte_count_i,
  input  wire logic [LENGTH_BITS-1:0]         total_length_i,
  input  wire logic                           first_word_i,
  input  wire logic                           last_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [63:0]                    hash_lane0_o,
  output logic      [63:0]                    hash_lane1_o,
  output logic      [63:0]                    hash_lane2_o,
  output logic      [63:0]                    hash_lane3_o
);

  import fh64_pkg::*;

  logic [NUM_OUT-1:0][63:0] seed_q;
  logic                     fold_q;
  logic [NUM_OUT-1:0][63:0] hash;
  dp_cmd_t                  cmd;
  dp_stat_t                 stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      fold_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i < CFG_FOLD) begin
        seed_q[cfg_index_i[SEED_IDX_W-1:0]] <= cfg_wdata_i;
      end else if (cfg_index_i == CFG_FOLD) begin
        fold_q <= cfg_wdata_i[0];
      end
    end
  end

  fh64_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fh64_datapath #(
    .LANES       (LANES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .data_word_i    (data_word_i),
    .byte_count_i   (byte_count_i),
    .total_length_i (total_length_i),
    .first_word_i   (first_word_i),
    .last_word_i    (last_word_i),
    .seed_i         (seed_q),
    .fold_i         (fold_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .hash_o         (hash)
  );

  assign hash_lane0_o = hash[0];
  assign hash_lane1_o = hash[1];
  assign hash_lane2_o = hash[2];
  assign hash_lane3_o = hash[3];

endmodule
`default_nettype wire
